// ===== rtl/svrp_pkg.sv =====
`default_nettype none
package svrp_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_AXIS_SCALE   = 3'd0,
		REG_ACCEL_LIMIT  = 3'd1,
		REG_MAX_RATE     = 3'd2,
		REG_PERIOD_SEC   = 3'd3,
		REG_PERIOD_RATE  = 3'd4,
		REG_VEL_WORD_GAIN = 3'd5
	} cfg_reg_t;

	localparam logic [31:0] RST_AXIS_SCALE  = 32'd65536;
	localparam logic [31:0] RST_ACCEL_LIMIT = 32'd65536;
	localparam logic [23:0] RST_MAX_RATE    = 24'd25000;
	localparam logic [31:0] RST_PERIOD_SEC  = 32'd4294967;
	localparam logic [19:0] RST_PERIOD_RATE = 20'd1000;
	localparam logic [31:0] RST_VEL_GAIN    = 32'd16777216;

	// saturation limits of the shared multiplier, the divider's quotient cap and the error tolerance
	localparam logic [63:0] LIM47  = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] LIM60  = 64'h1000_0000_0000_0000;
	localparam logic [63:0] LIM61  = 64'h2000_0000_0000_0000;
	localparam logic [63:0] LIM62  = 64'h4000_0000_0000_0000;
	localparam logic [63:0] LIMW   = 64'h0000_0000_8000_0000;
	localparam logic [51:0] TCAP   = {52{1'b1}};
	localparam logic [63:0] ERR_TOL = 64'd6;

	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		mag64 = a[63] ? (64'd0 - a) : a;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/step_velocity_ramp_planner.sv =====
`default_nettype none
// a result beat follows each input beat after up to ten passes through the shared
//   multiplier and one run of the match-time divider; when no acceleration is
//   available, the divider and the later multiplier passes but the last are skipped
// one item at a time: s_tready is high only while the sequencer idles, so a new input
//   beat is taken only once the previous result has been moved to the output register
// reset: arst_n clears the sequencer, the stored command and velocity, and loads
//   the register defaults
module step_velocity_ramp_planner #(
	parameter int STEP_FRACTION_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration write port
	input  wire                              cfg_we,
	input  wire [svrp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire [svrp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// input beats
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [111:0] s_tdata,   // position_command[47:0], feedback_position[111:48]
	// result beats
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [79:0]  m_tdata    // new_velocity[41:0], velocity_word[73:42], zero pad
);
	import svrp_pkg::*;

	// feedback scaling to counts Q.16
	localparam int FB_SH  = (STEP_FRACTION_BITS >= 16) ? STEP_FRACTION_BITS - 16 : 0;
	localparam int FB_EXP = (STEP_FRACTION_BITS >= 16) ? 0 : 16 - STEP_FRACTION_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_POS, ST_VCMD, ST_CUR, ST_ABS, ST_USER, ST_DIV,
		ST_T1, ST_T2, ST_D, ST_COR, ST_M, ST_CLAMP, ST_WORD, ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [31:0] axis_scale_q;
	logic [31:0] accel_limit_q, period_seconds_q, gain_q;
	logic [23:0] max_rate_q;
	logic [19:0] period_rate_q;

	// per-item working registers
	logic signed [47:0] pc_q, pos_q, lastcmd_q;
	logic signed [63:0] fb_q, e_q, nv_q;
	logic signed [31:0] scale_q;
	logic signed [41:0] vcmd_q, lastvel_q;
	logic signed [61:0] cur_q;
	logic [60:0] absmax_q, acc_q;
	logic [51:0] ti_q;
	logic [61:0] d_q;
	logic        s_q;
	logic signed [31:0] word_q;
	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;
	logic        mul_go_q, div_go_q;
	logic        mul_go_d, div_go_d;

	// shared multiplier operands
	logic signed [63:0] mul_a, mul_b, mul_res;
	logic [5:0]  mul_sh;
	logic [63:0] mul_lim;
	logic        mul_done;
	logic [51:0] div_q;
	logic        div_done;

	logic signed [63:0] vmax, vraw, old64, d64, nv_c, tdiff, wsat;
	logic [63:0] user_w, acc_w, dvel_mag, m_u;
	logic signed [63:0] dvel;
	logic [64:0] two_e;
	logic        same, flip, s_fin;

	always_comb begin
		vmax   = $signed({24'd0, max_rate_q, 16'd0});
		old64  = 64'(lastvel_q);
		d64    = $signed({2'b00, d_q});
		dvel   = 64'(vcmd_q) - old64;
		dvel_mag = mag64(dvel);
		tdiff  = $signed({11'd0, ti_q, 1'b0}) - $signed({31'd0, period_seconds_q, 1'b0})
			- $signed({32'd0, period_seconds_q});
		vraw   = mul_res;
		user_w = mul_res;
		acc_w  = (accel_limit_q != 32'd0 && user_w < {3'd0, absmax_q}) ? user_w
			: {3'd0, absmax_q};
		m_u    = mul_res;
		two_e  = {mag64(e_q), 1'b0};
		same   = s_q ? (e_q > 64'sd0) : (e_q < 64'sd0);
		flip   = (m_u != 64'd0) && same && ({1'b0, m_u} < two_e);
		s_fin  = s_q ^ flip;
		// correction path, held within one period's worth of acceleration
		nv_c   = 64'(vcmd_q) - mul_res;
		if (nv_c > old64 + d64) nv_c = old64 + d64;
		else if (nv_c < old64 - d64) nv_c = old64 - d64;
		wsat   = (mul_res > 64'sd2147483647) ? 64'sd2147483647 : mul_res;
	end

	// start pulses for the shared units, raised on entry to a multiply or divide step
	always_comb begin
		mul_go_d = 1'b0;
		div_go_d = 1'b0;
		case (state_q)
			ST_IDLE: mul_go_d = s_tvalid;
			ST_POS, ST_VCMD, ST_CUR, ST_ABS, ST_T1, ST_T2: mul_go_d = mul_done;
			ST_USER: div_go_d = mul_done && (acc_w != 64'd0);
			ST_DIV:  mul_go_d = div_done;
			ST_D: mul_go_d = mul_done && !((ti_q < {20'd0, period_seconds_q})
				&& (mag64(e_q) <= ERR_TOL));
			ST_CLAMP: mul_go_d = 1'b1;
			default: mul_go_d = 1'b0;
		endcase
	end

	// operand select per sequencer step
	always_comb begin
		mul_a = 64'sd0;
		mul_b = 64'sd0;
		mul_sh = 6'd0;
		mul_lim = LIM62;
		case (state_q)
			ST_POS: begin
				mul_a = 64'(pc_q); mul_b = 64'(scale_q); mul_sh = 6'd24; mul_lim = LIM47;
			end
			ST_VCMD: begin
				mul_a = 64'(pos_q) - 64'(lastcmd_q);
				mul_b = $signed({44'd0, period_rate_q});
			end
			ST_CUR: begin
				mul_a = fb_q; mul_b = $signed(64'd1 << FB_EXP);
				mul_sh = 6'(FB_SH); mul_lim = LIM60;
			end
			ST_ABS: begin
				mul_a = $signed({40'd0, max_rate_q});
				mul_b = $signed({44'd0, period_rate_q});
			end
			ST_USER: begin
				mul_a = $signed({32'd0, accel_limit_q});
				mul_b = $signed(mag64(64'(scale_q))); mul_sh = 6'd16;
			end
			ST_T1: begin
				mul_a = 64'(vcmd_q) + old64; mul_b = $signed({12'd0, ti_q});
				mul_sh = 6'd33; mul_lim = LIM61;
			end
			ST_T2: begin
				mul_a = 64'(vcmd_q); mul_b = tdiff; mul_sh = 6'd33; mul_lim = LIM61;
			end
			ST_D: begin
				mul_a = $signed({3'd0, acc_q}); mul_b = $signed({32'd0, period_seconds_q});
				mul_sh = 6'd32; mul_lim = LIM61;
			end
			ST_COR: begin
				mul_a = e_q; mul_b = $signed({44'd0, period_rate_q});
				mul_sh = 6'd1; mul_lim = LIM61;
			end
			ST_M: begin
				mul_a = d64; mul_b = $signed({12'd0, ti_q}); mul_sh = 6'd30;
			end
			ST_WORD: begin
				mul_a = nv_q; mul_b = $signed({32'd0, gain_q}); mul_sh = 6'd40; mul_lim = LIMW;
			end
			default: begin
				mul_a = 64'sd0;
			end
		endcase
	end

	svrp_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q),
		.a(mul_a), .b(mul_b), .sh(mul_sh), .lim(mul_lim),
		.done(mul_done), .res(mul_res)
	);

	svrp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q),
		.n(dvel_mag), .d({3'd0, acc_q}),
		.done(div_done), .q(div_q)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_scale_q     <= $signed(RST_AXIS_SCALE);
			accel_limit_q    <= RST_ACCEL_LIMIT;
			max_rate_q       <= RST_MAX_RATE;
			period_seconds_q <= RST_PERIOD_SEC;
			period_rate_q    <= RST_PERIOD_RATE;
			gain_q           <= RST_VEL_GAIN;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_AXIS_SCALE:    axis_scale_q     <= $signed(cfg_wdata);
				REG_ACCEL_LIMIT:   accel_limit_q    <= cfg_wdata;
				REG_MAX_RATE:      max_rate_q       <= cfg_wdata[23:0];
				REG_PERIOD_SEC:    period_seconds_q <= cfg_wdata;
				REG_PERIOD_RATE:   period_rate_q    <= cfg_wdata[19:0];
				REG_VEL_WORD_GAIN: gain_q           <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer: each multiplier step pulses mul_go_q on entry and waits for done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mul_go_q   <= 1'b0;
			div_go_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			lastcmd_q  <= 48'sd0;
			lastvel_q  <= 42'sd0;
		end else begin
			mul_go_q <= mul_go_d;
			div_go_q <= div_go_d;
			if (m_tvalid_q && m_tready && state_q != ST_OUT) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						pc_q     <= $signed(s_tdata[47:0]);
						fb_q     <= $signed(s_tdata[111:48]);
						// zero scale acts as 1.0
						scale_q  <= (axis_scale_q == 32'sd0) ? $signed(RST_AXIS_SCALE) : axis_scale_q;
						state_q  <= ST_POS;
					end
				end
				ST_POS: if (mul_done) begin
					pos_q    <= 48'(mul_res);
					state_q  <= ST_VCMD;
				end
				ST_VCMD: if (mul_done) begin
					if (vraw > vmax) vcmd_q <= 42'(vmax);
					else if (vraw < -vmax) vcmd_q <= 42'(-vmax);
					else vcmd_q <= 42'(vraw);
					lastcmd_q <= pos_q;
					state_q   <= ST_CUR;
				end
				ST_CUR: if (mul_done) begin
					cur_q    <= 62'(mul_res);
					state_q  <= ST_ABS;
				end
				ST_ABS: if (mul_done) begin
					absmax_q <= {mul_res[44:0], 16'd0};
					state_q  <= ST_USER;
				end
				ST_USER: if (mul_done) begin
					acc_q <= acc_w[60:0];
					s_q   <= dvel > 64'sd0;
					if (acc_w == 64'd0) begin
						// no acceleration available: hold the velocity
						nv_q    <= old64;
						state_q <= ST_CLAMP;
					end else begin
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: if (div_done) begin
					ti_q     <= div_q;
					state_q  <= ST_T1;
				end
				ST_T1: if (mul_done) begin
					e_q      <= 64'(cur_q) + mul_res - 64'(pos_q);
					state_q  <= ST_T2;
				end
				ST_T2: if (mul_done) begin
					e_q      <= e_q - mul_res;
					state_q  <= ST_D;
				end
				ST_D: if (mul_done) begin
					d_q <= mul_res[61:0];
					if (ti_q < {20'd0, period_seconds_q}) begin
						// velocity can be matched within the period
						if (mag64(e_q) <= ERR_TOL) begin
							nv_q    <= 64'(vcmd_q);
							state_q <= ST_CLAMP;
						end else begin
							state_q  <= ST_COR;
						end
					end else begin
						state_q  <= ST_M;
					end
				end
				ST_COR: if (mul_done) begin
					nv_q    <= nv_c;
					state_q <= ST_CLAMP;
				end
				ST_M: if (mul_done) begin
					// ramp, reversing when the predicted error shrinks
					nv_q    <= s_fin ? old64 + d64 : old64 - d64;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (nv_q > vmax) begin
						nv_q <= vmax; lastvel_q <= 42'(vmax);
					end else if (nv_q < -vmax) begin
						nv_q <= -vmax; lastvel_q <= 42'(-vmax);
					end else begin
						lastvel_q <= 42'(nv_q);
					end
					state_q  <= ST_WORD;
				end
				ST_WORD: if (mul_done) begin
					word_q  <= 32'(wsat);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// output register parts the sequencer from the result side
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {6'd0, word_q, lastvel_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a beat but stayed ready");

	a_mul_done_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q != ST_IDLE && state_q != ST_OUT && state_q != ST_DIV))
		else $error("multiplier finished outside a multiply step");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_vel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WORD |-> (nv_q <= vmax && nv_q >= -vmax))
		else $error("planned velocity beyond max rate");

endmodule
`default_nettype wire

// ===== rtl/svrp_mul.sv =====
`default_nettype none
module svrp_mul (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire signed [63:0]  a,
	input  wire signed [63:0]  b,
	input  wire        [5:0]   sh,
	input  wire        [63:0]  lim,
	output logic               done,
	output logic signed [63:0] res
);
	import svrp_pkg::*;

	logic         busy_q;
	logic [2:0]   cnt_q;
	logic [63:0]  ua_q, ub_q, lim_q;
	logic         neg_q;
	logic [5:0]   sh_q;
	logic [127:0] prod_q;
	logic         done_q;
	logic signed [63:0] res_q;

	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] pp_w;
	logic [127:0] shifted;
	logic [63:0]  m;

	// one 32x32 partial product per cycle
	always_comb begin
		pa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		pb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		pp = pa * pb;
		case (2'(cnt_q[1]) + 2'(cnt_q[0]))
			2'd0:    pp_w = {64'd0, pp};
			2'd1:    pp_w = {32'd0, pp, 32'd0};
			default: pp_w = {pp, 64'd0};
		endcase
		shifted = prod_q >> sh_q;
		m = (shifted[127:64] != 64'd0 || shifted[63:0] > lim_q) ? lim_q : shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 3'd4);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q   <= mag64(a);
			ub_q   <= mag64(b);
			neg_q  <= a[63] ^ b[63];
			sh_q   <= sh;
			lim_q  <= lim;
			prod_q <= 128'd0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				res_q <= neg_q ? $signed(64'd0 - m) : $signed(m);
			end else begin
				prod_q <= prod_q + pp_w;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// ===== rtl/svrp_div.sv =====
`default_nettype none
module svrp_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [63:0] n,
	input  wire  [63:0] d,
	output logic        done,
	output logic [51:0] q
);
	import svrp_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] r_q, d_q;
	logic [19:0] sr_q;
	logic [51:0] q_q;
	logic        done_q;

	logic [64:0] rr;
	logic        ge;
	logic        ovf;

	always_comb begin
		rr  = {r_q, sr_q[19]};
		ge  = rr >= {1'b0, d_q};
		ovf = {20'd0, n} >= {d, 20'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= start ? ovf : (busy_q && (cnt_q == 6'd0));
			if (start) begin
				busy_q <= !ovf;
				cnt_q  <= 6'd51;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			d_q  <= d;
			r_q  <= {20'd0, n[63:20]};
			sr_q <= n[19:0];
			q_q  <= ovf ? TCAP : 52'd0;
		end else if (busy_q) begin
			r_q  <= ge ? 64'(rr - {1'b0, d_q}) : rr[63:0];
			sr_q <= {sr_q[18:0], 1'b0};
			q_q  <= {q_q[50:0], ge};
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule
`default_nettype wire
